[rtl/core/qmm_pkg.sv]
// Shared types, constants and helpers of the quad motor mixer.
`timescale 1ns / 1ps
`default_nettype none

package qmm_pkg;

  localparam int unsigned ADDR_W      = 3;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned DUTY_W      = 16;
  localparam int unsigned VALUE_W     = 24;
  localparam int unsigned THROTTLE_W  = 8;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [DUTY_W-1:0] DUTY_MIN_RST = 16'h0000;
  localparam logic [DUTY_W-1:0] DUTY_MAX_RST = 16'hFFFF;

  // Register select is address bit 2.
  localparam logic REG_DUTY_MIN = 1'b0;
  localparam logic REG_DUTY_MAX = 1'b1;

  // Motor channel numbers.
  localparam logic [1:0] CH_FRONT = 2'd0;
  localparam logic [1:0] CH_LEFT  = 2'd1;
  localparam logic [1:0] CH_BACK  = 2'd2;
  localparam logic [1:0] CH_RIGHT = 2'd3;

  // Write order positions.
  localparam logic [1:0] ORD_FRONT = 2'd0;
  localparam logic [1:0] ORD_BACK  = 2'd1;
  localparam logic [1:0] ORD_LEFT  = 2'd2;
  localparam logic [1:0] ORD_RIGHT = 2'd3;

  typedef struct packed {
    logic                         pitch_valid;
    logic signed [VALUE_W-1:0]    pitch_value;
    logic                         roll_valid;
    logic signed [VALUE_W-1:0]    roll_value;
    logic                         yaw_valid;
    logic signed [VALUE_W-1:0]    yaw_value;
    logic                         throttle_valid;
    logic [THROTTLE_W-1:0]        throttle_value;
  } qmm_in_t;

  typedef struct packed {
    logic [1:0]        channel;
    logic [DUTY_W-1:0] duty_value;
    logic              final_write;
  } qmm_out_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty_min;
    logic [DUTY_W-1:0] duty_max;
  } qmm_cfg_t;

  typedef struct packed {
    logic [3:0]              mask;
    logic [3:0][DUTY_W-1:0]  duty;
  } qmm_entry_t;

  function automatic logic [1:0] order_channel(logic [1:0] ord);
    logic [1:0] ch;
    unique case (ord)
      ORD_FRONT: ch = CH_FRONT;
      ORD_BACK:  ch = CH_BACK;
      ORD_LEFT:  ch = CH_LEFT;
      default:   ch = CH_RIGHT;
    endcase
    return ch;
  endfunction

  function automatic logic [1:0] channel_order(logic [1:0] ch);
    logic [1:0] ord;
    unique case (ch)
      CH_FRONT: ord = ORD_FRONT;
      CH_BACK:  ord = ORD_BACK;
      CH_LEFT:  ord = ORD_LEFT;
      default:  ord = ORD_RIGHT;
    endcase
    return ord;
  endfunction

endpackage

`default_nettype wire

[rtl/core/qmm_front.sv]
// Front end: holds the latest set points, mixes, detects changes and clamps.
`timescale 1ns / 1ps
`default_nettype none

module qmm_front import qmm_pkg::*; #(
  parameter int unsigned FRACTION_BITS = 8
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire qmm_in_t    in_word_i,
  input  wire qmm_cfg_t   cfg_i,
  output logic            push_o,
  output qmm_entry_t      entry_o,
  input  wire logic       full_i
);

  localparam int unsigned CMD_W =
      ((FRACTION_BITS + THROTTLE_W + 1 > VALUE_W) ? FRACTION_BITS + THROTTLE_W + 1
                                                   : VALUE_W) + 2;
  localparam int unsigned WHOLE_W = CMD_W;

  typedef logic signed [CMD_W-1:0] cmd_t;

  logic signed [VALUE_W-1:0] pitch_q, roll_q, yaw_q;
  logic [THROTTLE_W-1:0]     thr_q;
  logic                      pend_q;
  cmd_t                      prev_q [4];
  cmd_t                      cmd_q [4];
  logic [3:0]                mask_q;
  logic                      b_valid_q;

  cmd_t       thr_ext, p_ext, r_ext, y_ext;
  cmd_t       cmd_new [4];
  logic [3:0] changed;
  logic       b_ready, a_move, accept;

  function automatic logic [DUTY_W-1:0] clamp_duty(cmd_t c, qmm_cfg_t cfg);
    logic [WHOLE_W-1:0] whole;
    logic [DUTY_W-1:0]  v;
    whole = c >>> FRACTION_BITS;
    if (c[CMD_W-1]) begin
      v = cfg.duty_min;
    end else begin
      if (whole > WHOLE_W'(cfg.duty_max)) begin
        v = cfg.duty_max;
      end else begin
        v = whole[DUTY_W-1:0];
      end
      if (v < cfg.duty_min) begin
        v = cfg.duty_min;
      end
    end
    return v;
  endfunction

  assign thr_ext = cmd_t'(thr_q) << FRACTION_BITS;
  assign p_ext   = cmd_t'(pitch_q);
  assign r_ext   = cmd_t'(roll_q);
  assign y_ext   = cmd_t'(yaw_q);

  always_comb begin
    cmd_new[ORD_FRONT] = thr_ext + p_ext - y_ext;
    cmd_new[ORD_BACK]  = thr_ext - p_ext - y_ext;
    cmd_new[ORD_LEFT]  = thr_ext - r_ext + y_ext;
    cmd_new[ORD_RIGHT] = thr_ext + r_ext + y_ext;
    for (int k = 0; k < 4; k++) begin
      changed[k] = (cmd_new[k] != prev_q[k]);
    end
  end

  assign push_o     = b_valid_q && (mask_q != 4'b0) && !full_i;
  assign b_ready    = !b_valid_q || (mask_q == 4'b0) || !full_i;
  assign a_move     = pend_q && b_ready;
  assign in_stall_o = pend_q && !b_ready;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    entry_o.mask = mask_q;
    for (int k = 0; k < 4; k++) begin
      entry_o.duty[k] = clamp_duty(cmd_q[k], cfg_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pitch_q   <= '0;
      roll_q    <= '0;
      yaw_q     <= '0;
      thr_q     <= '0;
      pend_q    <= 1'b0;
      b_valid_q <= 1'b0;
      mask_q    <= '0;
      for (int k = 0; k < 4; k++) begin
        prev_q[k] <= '0;
      end
    end else begin
      if (accept) begin
        if (in_word_i.pitch_valid)    pitch_q <= in_word_i.pitch_value;
        if (in_word_i.roll_valid)     roll_q  <= in_word_i.roll_value;
        if (in_word_i.yaw_valid)      yaw_q   <= in_word_i.yaw_value;
        if (in_word_i.throttle_valid) thr_q   <= in_word_i.throttle_value;
        pend_q <= 1'b1;
      end else if (a_move) begin
        pend_q <= 1'b0;
      end
      if (a_move) begin
        b_valid_q <= 1'b1;
        mask_q    <= changed;
        for (int k = 0; k < 4; k++) begin
          if (changed[k]) prev_q[k] <= cmd_new[k];
        end
      end else if (b_ready) begin
        b_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_move) begin
      for (int k = 0; k < 4; k++) begin
        cmd_q[k] <= cmd_new[k];
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/qmm_queue.sv]
// Short register queue between the front end and the write sequencer.
`timescale 1ns / 1ps
`default_nettype none

module qmm_queue import qmm_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  wire qmm_entry_t  entry_i,
  output logic             full_o,
  input  wire logic        pop_i,
  output qmm_entry_t       head_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  qmm_entry_t       mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  function automatic logic [PTR_W-1:0] next_ptr(logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] n;
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      n = '0;
    end else begin
      n = p + PTR_W'(1);
    end
    return n;
  endfunction

  assign full_o  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= next_ptr(wr_ptr_q);
      if (pop_i)  rd_ptr_q <= next_ptr(rd_ptr_q);
      if (push_i && !pop_i) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= entry_i;
  end

endmodule

`default_nettype wire

[rtl/core/qmm_back.sv]
// Back end: walks the queue head's changed motors, one write per cycle unless stalled.
`timescale 1ns / 1ps
`default_nettype none

module qmm_back import qmm_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire qmm_entry_t  head_i,
  input  wire logic        empty_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output qmm_out_t         out_word_o
);

  logic       rem_used_q;
  logic [3:0] rem_q;
  logic       out_valid_q;
  qmm_out_t   out_q;

  logic [3:0] eff, rest;
  logic [1:0] ord;
  logic       slot_free, emit;

  assign eff = rem_used_q ? rem_q : head_i.mask;

  always_comb begin
    priority if (eff[ORD_FRONT]) begin
      ord = ORD_FRONT;
    end else if (eff[ORD_BACK]) begin
      ord = ORD_BACK;
    end else if (eff[ORD_LEFT]) begin
      ord = ORD_LEFT;
    end else begin
      ord = ORD_RIGHT;
    end
  end

  assign rest      = eff & ~(4'b0001 << ord);
  assign slot_free = !out_valid_q || !out_stall_i;
  assign emit      = !empty_i && slot_free;
  assign pop_o     = emit && (rest == 4'b0);

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_used_q  <= 1'b0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
        rem_used_q  <= (rest != 4'b0);
        rem_q       <= rest;
      end else if (slot_free) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q.channel     <= order_channel(ord);
      out_q.duty_value  <= head_i.duty[ord];
      out_q.final_write <= (rest == 4'b0);
    end
  end

endmodule

`default_nettype wire

[rtl/core/quad_motor_mixer.sv]
// Top level of the plus-layout quadcopter motor mixer.
//
//   Channel  Direction  Handshake                 Word
//   in       sink       in_valid_i / in_stall_o   qmm_in_t  (set point update)
//   out      source     out_valid_o / out_stall_i qmm_out_t (one motor write)
//   config   APB slave  psel / penable / pready   duty_min at 0x0, duty_max at 0x4
//
// An update word can be taken every cycle while in_stall_o is low; the output side
// issues one motor write per cycle while out_stall_i is low, once per changed motor.
// An update's first write passes the set-point, command, queue and output registers.
// A two-entry queue between mixing and write sequencing absorbs output stalls.
// Reset clears the held set points and the last commands to zero and needs no sweep.
`timescale 1ns / 1ps
`default_nettype none

module quad_motor_mixer import qmm_pkg::*; #(
  parameter int unsigned FRACTION_BITS = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire qmm_in_t           in_word_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output qmm_out_t               out_word_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready
);

  qmm_cfg_t   cfg_q;
  qmm_entry_t q_entry, q_head;
  logic       q_push, q_full, q_pop, q_empty;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_DUTY_MAX) ? DATA_W'(cfg_q.duty_max)
                                             : DATA_W'(cfg_q.duty_min);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.duty_min <= DUTY_MIN_RST;
      cfg_q.duty_max <= DUTY_MAX_RST;
    end else if (wr_en) begin
      if (paddr[2] == REG_DUTY_MIN) begin
        cfg_q.duty_min <= pwdata[DUTY_W-1:0];
      end else begin
        cfg_q.duty_max <= pwdata[DUTY_W-1:0];
      end
    end
  end

  qmm_front #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .cfg_i      (cfg_q),
    .push_o     (q_push),
    .entry_o    (q_entry),
    .full_i     (q_full)
  );

  qmm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .head_o  (q_head),
    .empty_o (q_empty)
  );

  qmm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (q_head),
    .empty_i     (q_empty),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire

[rtl/core/qmm_checker.sv]
// Port-level checker for the quad motor mixer and its bind statement.
`timescale 1ns / 1ps
`default_nettype none

module qmm_checker import qmm_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              out_valid_o,
  input  wire logic              out_stall_i,
  input  wire qmm_out_t          out_word_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic              pready,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata
);

  logic [DUTY_W-1:0] min_q, max_q;
  logic [1:0]        last_ord_q;
  logic              last_final_q;
  logic              out_acc;

  assign out_acc = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q        <= DUTY_MIN_RST;
      max_q        <= DUTY_MAX_RST;
      last_ord_q   <= ORD_FRONT;
      last_final_q <= 1'b1;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_DUTY_MIN) begin
          min_q <= pwdata[DUTY_W-1:0];
        end else begin
          max_q <= pwdata[DUTY_W-1:0];
        end
      end
      if (out_acc) begin
        last_ord_q   <= channel_order(out_word_o.channel);
        last_final_q <= out_word_o.final_write;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("Stalled output word changed or was dropped.");

  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((min_q > max_q) ? (out_word_o.duty_value == min_q)
                     : (out_word_o.duty_value >= min_q && out_word_o.duty_value <= max_q)))
    else $error("Motor write lies outside the configured duty range.");

  a_write_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !last_final_q |-> channel_order(out_word_o.channel) > last_ord_q)
    else $error("Motor writes of one update are out of order or repeated.");

endmodule

bind quad_motor_mixer qmm_checker u_checker (.*);

`default_nettype wire
